### design/kfsi_pkg.sv
// kfsi_pkg: shared types and codes for the keyframe sampler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package kfsi_pkg;

  // input operation codes
  localparam logic [1:0] OP_LOAD_TIME = 2'd0;
  localparam logic [1:0] OP_LOAD_VEC  = 2'd1;
  localparam logic [1:0] OP_SAMPLE    = 2'd2;

  // item kinds after classification
  localparam logic [1:0] KIND_TIME   = 2'd0;
  localparam logic [1:0] KIND_VEC    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // vector slots
  localparam logic [1:0] SLOT_IN    = 2'd0;
  localparam logic [1:0] SLOT_VALUE = 2'd1;
  localparam logic [1:0] SLOT_OUT   = 2'd2;

  // interpolation modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_CUBIC  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_KEYS     = 2'd1;
  localparam logic [1:0] CFG_DURATION = 2'd2;
  localparam logic [1:0] CFG_COMPS    = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       key_index;
    logic [1:0]       vector_slot;
    logic [31:0]      key_time;
    logic [3:0][31:0] comps;
    logic [16:0]      play_fraction;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  key_count;
    logic [31:0] duration;
    logic [2:0]  comp_count;
  } cfg_t;

endpackage
`default_nettype wire

### design/kfsi_front.sv
// kfsi_front: accepts command words, classifies them and queues them.
// Two-entry queue in front of the sequencer; uses kfsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfsi_front #(
  parameter int MAX_KEYS = 256
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire [1:0]            in_operation,
  input  wire [7:0]            in_key_index,
  input  wire [1:0]            in_vector_slot,
  input  wire [31:0]           in_key_time,
  input  wire [3:0][31:0]      in_comps,
  input  wire [16:0]           in_play_fraction,
  output logic                 q_valid,
  output kfsi_pkg::item_t      q_item,
  input  wire                  q_take
);
  import kfsi_pkg::*;

  item_t       fifo_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        accept, keep, push, pop, key_ok, slot_ok;
  item_t       new_item;

  assign busy    = (cnt_r == 2'd2);
  assign accept  = start && !busy;
  assign key_ok  = (32'(in_key_index) < 32'(MAX_KEYS));
  assign slot_ok = (in_vector_slot == SLOT_IN) || (in_vector_slot == SLOT_VALUE) ||
                   (in_vector_slot == SLOT_OUT);

  // bad loads and unknown operations are dropped here
  always_comb begin
    new_item.key_index     = in_key_index;
    new_item.vector_slot   = in_vector_slot;
    new_item.key_time      = in_key_time;
    new_item.comps         = in_comps;
    new_item.play_fraction = in_play_fraction;
    case (in_operation)
      OP_LOAD_TIME: begin
        new_item.kind = KIND_TIME;
        keep = key_ok;
      end
      OP_LOAD_VEC: begin
        new_item.kind = KIND_VEC;
        keep = key_ok && slot_ok;
      end
      OP_SAMPLE: begin
        new_item.kind = KIND_SAMPLE;
        keep = 1'b1;
      end
      default: begin
        new_item.kind = KIND_SAMPLE;
        keep = 1'b0;
      end
    endcase
  end

  assign push    = accept && keep;
  assign pop     = q_take && (cnt_r != 2'd0);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= new_item;
  end

endmodule
`default_nettype wire

### design/kfsi_div.sv
// kfsi_div: restoring unsigned divider, one quotient bit per cycle.
// Shared by the time wrap and the fraction; uses kfsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfsi_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           go,
  input  wire [DW-1:0]  dividend,
  input  wire [VW-1:0]  divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);
  import kfsi_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          run_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic [VW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_r, q_r[DW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});
  assign done  = done_r;
  assign quot  = q_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### design/kfsi_back.sv
// kfsi_back: executes queued words; holds the key tables and runs the sample
// sequence (scan, wrap, search, fraction, interpolation). Uses kfsi_pkg, kfsi_div.
`timescale 1ns / 1ps
`default_nettype none
module kfsi_back #(
  parameter int MAX_KEYS       = 256,
  parameter int NUM_COMPONENTS = 4
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  kfsi_pkg::cfg_t       cfg,
  input  wire                  q_valid,
  input  kfsi_pkg::item_t      q_item,
  output logic                 q_take,
  output logic                 out_valid,
  output logic [3:0][31:0]     out_comps,
  output logic [7:0]           out_start_key,
  output logic [7:0]           out_end_key
);
  import kfsi_pkg::*;

  localparam int KW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int RW = $clog2(MAX_KEYS * 3);

  localparam logic [3:0] S_IDLE = 4'd0,  S_TMUL = 4'd1,  S_SCAN = 4'd2,  S_WRAP = 4'd3,
                         S_MOD  = 4'd4,  S_SCHK = 4'd5,  S_SRCH = 4'd6,  S_RDS  = 4'd7,
                         S_RDE  = 4'd8,  S_RTS  = 4'd9,  S_FRAC = 4'd10, S_FDIV = 4'd11,
                         S_VRD  = 4'd12, S_COMP = 4'd13, S_CALC = 4'd14, S_OUT  = 4'd15;

  // multiply steps; the cubic ones run in order
  localparam logic [3:0] M_T2 = 4'd0, M_T3 = 4'd1, M_M0L = 4'd2, M_M0H = 4'd3,
                         M_M1L = 4'd4, M_M1H = 4'd5, M_A0 = 4'd6, M_A1 = 4'd7,
                         M_A2 = 4'd8, M_A3 = 4'd9, M_A4 = 4'd10, M_A5 = 4'd11,
                         M_LIN = 4'd12;

  localparam logic signed [71:0] SAT_MAX = 72'sh7FFF_FFFF;
  localparam logic signed [71:0] SAT_MIN = -72'sh8000_0000;

  function automatic logic [RW-1:0] row_of(input logic [KW-1:0] k, input logic [1:0] sl);
    row_of = RW'({k, 1'b0}) + RW'(k) + RW'(sl);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [71:0] x);
    if (x > SAT_MAX) sat32 = 32'h7FFF_FFFF;
    else if (x < SAT_MIN) sat32 = 32'h8000_0000;
    else sat32 = x[31:0];
  endfunction

  logic [31:0]                      time_mem [MAX_KEYS];
  logic [NUM_COMPONENTS-1:0][31:0]  vec_mem  [MAX_KEYS*3];

  logic [3:0]   state_r, st_r;
  logic         ph_r, pv_r;
  logic [16:0]  fr_r, d_r, t2_r, t3_r;
  logic [32:0]  t_r;
  logic [31:0]  mx_r, t0_r, last_r, ts_r, tdata_r;
  logic [NW-1:0] n_r;
  logic [KW-1:0] ti_r, pidx_r, s_r, e_r, nm1;
  logic signed [33:0] den_r;
  logic [NUM_COMPONENTS-1:0][31:0] p0_r, p1_r, g0_r, g1_r, vdata_r;
  logic [2:0]   vcnt_r, c_r, used;
  logic signed [51:0] prod_r;
  logic signed [49:0] m0_r, m1_r;
  logic signed [71:0] acc_r, acc_nxt;
  logic [3:0][31:0]   res_r;

  logic         div_go_r, div_done;
  logic [47:0]  div_a_r, div_quot;
  logic [31:0]  div_b_r, div_rem;

  logic         tw_en, vw_en, cub;
  logic [RW-1:0] wrow, vaddr;
  logic [NUM_COMPONENTS-1:0][31:0] wdata;
  logic [31:0]  p0c, p1c, g0c, g1c;
  logic signed [33:0] op_a, num;
  logic signed [17:0] op_b;
  logic signed [19:0] t2s, t3s, ds;
  logic signed [17:0] h00, h10, h01, h11;
  logic [33:0]  an, ad;
  logic [NW-1:0] nsat;

  kfsi_div #(.DW(48), .VW(32)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign q_take = (state_r == S_IDLE);
  assign tw_en  = (state_r == S_IDLE) && q_valid && (q_item.kind == KIND_TIME);
  assign vw_en  = (state_r == S_IDLE) && q_valid && (q_item.kind == KIND_VEC);
  assign wrow   = row_of(KW'(q_item.key_index), q_item.vector_slot);
  assign nm1    = KW'(n_r - NW'(1));
  assign nsat   = (32'(cfg.key_count) > 32'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(cfg.key_count);
  assign used   = (32'(cfg.comp_count) > 32'(NUM_COMPONENTS)) ? 3'(NUM_COMPONENTS)
                                                             : cfg.comp_count;
  assign cub    = (cfg.mode == MODE_CUBIC) && (s_r != e_r);

  always_comb begin
    for (int k = 0; k < NUM_COMPONENTS; k++) wdata[k] = q_item.comps[k];
  end

  always_comb begin
    case (vcnt_r)
      3'd0:    vaddr = row_of(s_r, SLOT_VALUE);
      3'd1:    vaddr = row_of(e_r, SLOT_VALUE);
      3'd2:    vaddr = row_of(s_r, SLOT_OUT);
      default: vaddr = row_of(e_r, SLOT_IN);
    endcase
  end

  always_ff @(posedge clk) begin
    if (tw_en) time_mem[KW'(q_item.key_index)] <= q_item.key_time;
    if (vw_en) vec_mem[wrow] <= wdata;
    tdata_r <= time_mem[ti_r];
    vdata_r <= vec_mem[vaddr];
  end

  // component currently worked on
  always_comb begin
    p0c = '0;
    p1c = '0;
    g0c = '0;
    g1c = '0;
    for (int k = 0; k < NUM_COMPONENTS; k++) begin
      if (c_r == 3'(k)) begin
        p0c = p0_r[k];
        p1c = p1_r[k];
        g0c = g0_r[k];
        g1c = g1_r[k];
      end
    end
  end

  // Hermite basis weights
  assign t2s = $signed({3'b0, t2_r});
  assign t3s = $signed({3'b0, t3_r});
  assign ds  = $signed({3'b0, d_r});
  assign h00 = 18'(2 * t3s - 3 * t2s + 20'sd65536);
  assign h10 = 18'(t3s - 2 * t2s + ds);
  assign h01 = 18'(3 * t2s - 2 * t3s);
  assign h11 = 18'(t3s - t2s);

  always_comb begin
    case (st_r)
      M_T2: begin op_a = $signed({17'b0, d_r}); op_b = $signed({1'b0, d_r}); end
      M_T3: begin op_a = $signed({17'b0, t2_r}); op_b = $signed({1'b0, d_r}); end
      M_M0L: begin op_a = den_r; op_b = $signed({2'b0, g0c[15:0]}); end
      M_M0H: begin op_a = den_r; op_b = 18'($signed(g0c[31:16])); end
      M_M1L: begin op_a = den_r; op_b = $signed({2'b0, g1c[15:0]}); end
      M_M1H: begin op_a = den_r; op_b = 18'($signed(g1c[31:16])); end
      M_A0: begin op_a = 34'($signed(p0c)); op_b = h00; end
      M_A1: begin op_a = 34'($signed(p1c)); op_b = h01; end
      M_A2: begin op_a = $signed({2'b0, m0_r[31:0]}); op_b = h10; end
      M_A3: begin op_a = 34'($signed(m0_r[49:32])); op_b = h10; end
      M_A4: begin op_a = $signed({2'b0, m1_r[31:0]}); op_b = h11; end
      M_A5: begin op_a = 34'($signed(m1_r[49:32])); op_b = h11; end
      default: begin
        op_a = 34'($signed(p1c)) - 34'($signed(p0c));
        op_b = $signed({1'b0, d_r});
      end
    endcase
  end

  always_comb begin
    case (st_r)
      M_A0:        acc_nxt = 72'(prod_r);
      M_A3, M_A5:  acc_nxt = acc_r + (72'(prod_r) <<< 32);
      default:     acc_nxt = acc_r + 72'(prod_r);
    endcase
  end

  assign num = $signed({1'b0, t_r}) - $signed({2'b0, ts_r});
  assign an  = num[33] ? 34'(-num) : 34'(num);
  assign ad  = den_r[33] ? 34'(-den_r) : 34'(den_r);

  assign out_valid     = (state_r == S_OUT);
  assign out_comps     = res_r;
  assign out_start_key = 8'(s_r);
  assign out_end_key   = 8'(e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      div_go_r <= 1'b0;
      pv_r     <= 1'b0;
      ph_r     <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid && (q_item.kind == KIND_SAMPLE) && (cfg.key_count != 9'd0)) begin
            n_r     <= nsat;
            fr_r    <= q_item.play_fraction;
            res_r   <= '0;
            state_r <= S_TMUL;
          end
        end
        S_TMUL: begin
          t_r     <= 33'((49'(fr_r) * 49'(cfg.duration)) >> 16);
          ti_r    <= '0;
          pv_r    <= 1'b0;
          mx_r    <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // address runs one ahead of the registered read data
          ti_r   <= ti_r + KW'(1);
          pv_r   <= 1'b1;
          pidx_r <= ti_r;
          if (pv_r) begin
            if (tdata_r > mx_r) mx_r <= tdata_r;
            if (pidx_r == '0) t0_r <= tdata_r;
            if (pidx_r == nm1) begin
              last_r  <= tdata_r;
              state_r <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          if (t_r > {1'b0, mx_r}) begin
            if (last_r == '0) begin
              t_r     <= {1'b0, mx_r};
              state_r <= S_SCHK;
            end else begin
              div_go_r <= 1'b1;
              div_a_r  <= 48'(t_r - {1'b0, mx_r});
              div_b_r  <= last_r;
              state_r  <= S_MOD;
            end
          end else begin
            state_r <= S_SCHK;
          end
        end
        S_MOD: begin
          // t drops by whole periods until it is at most the largest key time
          if (div_done) begin
            t_r <= (div_rem == '0) ? {1'b0, mx_r}
                                   : {1'b0, mx_r} - {1'b0, last_r} + {1'b0, div_rem};
            state_r <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (t_r > {1'b0, t0_r}) begin
            ti_r    <= KW'(1);
            pv_r    <= 1'b0;
            state_r <= S_SRCH;
          end else begin
            s_r     <= '0;
            e_r     <= '0;
            state_r <= S_RDS;
          end
        end
        S_SRCH: begin
          ti_r   <= ti_r + KW'(1);
          pv_r   <= 1'b1;
          pidx_r <= ti_r;
          if (pv_r && ((t_r <= {1'b0, tdata_r}) || (pidx_r == nm1))) begin
            e_r     <= pidx_r;
            s_r     <= pidx_r - KW'(1);
            state_r <= S_RDS;
          end
        end
        S_RDS: begin
          ti_r    <= s_r;
          state_r <= S_RDE;
        end
        S_RDE: begin
          ti_r    <= e_r;
          state_r <= S_RTS;
        end
        S_RTS: begin
          ts_r    <= tdata_r;
          state_r <= S_FRAC;
        end
        S_FRAC: begin
          den_r  <= $signed({2'b0, tdata_r}) - $signed({2'b0, ts_r});
          vcnt_r <= '0;
          pv_r   <= 1'b0;
          state_r <= S_VRD;
          d_r    <= '0;
          if ((tdata_r != ts_r) && (num != '0) && (num[33] == (tdata_r < ts_r))) begin
            if (an >= (tdata_r < ts_r ? 34'(ts_r) - 34'(tdata_r)
                                      : 34'(tdata_r) - 34'(ts_r))) begin
              d_r <= 17'd65536;
            end else begin
              state_r <= S_FDIV;
            end
          end
        end
        S_FDIV: begin
          if (!pv_r) begin
            div_go_r <= 1'b1;
            div_a_r  <= {an[31:0], 16'b0};
            div_b_r  <= ad[31:0];
            pv_r     <= 1'b1;
          end else if (div_done) begin
            d_r     <= 17'(div_quot);
            pv_r    <= 1'b0;
            state_r <= S_VRD;
          end
        end
        S_VRD: begin
          vcnt_r <= vcnt_r + 3'd1;
          case (vcnt_r)
            3'd1:    p0_r <= vdata_r;
            3'd2:    p1_r <= vdata_r;
            3'd3:    g0_r <= vdata_r;
            3'd4:    g1_r <= vdata_r;
            default: ;
          endcase
          if (vcnt_r == 3'd4) begin
            c_r  <= '0;
            ph_r <= 1'b0;
            st_r <= M_T2;
            state_r <= cub ? S_CALC : S_COMP;
          end
        end
        S_COMP: begin
          ph_r <= 1'b0;
          if (c_r >= used) begin
            state_r <= S_OUT;
          end else if (cfg.mode == MODE_LINEAR) begin
            st_r    <= M_LIN;
            state_r <= S_CALC;
          end else if (cub) begin
            st_r    <= M_M0L;
            state_r <= S_CALC;
          end else begin
            res_r[c_r[1:0]] <= p0c;
            c_r <= c_r + 3'd1;
          end
        end
        S_CALC: begin
          ph_r <= ~ph_r;
          if (!ph_r) begin
            prod_r <= op_a * op_b;
          end else begin
            st_r <= st_r + 4'd1;
            case (st_r)
              M_T2: t2_r <= prod_r[32:16];
              M_T3: begin
                t3_r    <= prod_r[32:16];
                state_r <= S_COMP;
              end
              M_M0L: m0_r <= 50'(prod_r >>> 16);
              M_M0H: m0_r <= m0_r + 50'(prod_r);
              M_M1L: m1_r <= 50'(prod_r >>> 16);
              M_M1H: m1_r <= m1_r + 50'(prod_r);
              M_A5: begin
                res_r[c_r[1:0]] <= sat32(acc_nxt >>> 16);
                c_r     <= c_r + 3'd1;
                state_r <= S_COMP;
              end
              M_LIN: begin
                res_r[c_r[1:0]] <= sat32(72'($signed(p0c)) + 72'(prod_r >>> 16));
                c_r     <= c_r + 3'd1;
                state_r <= S_COMP;
              end
              default: acc_r <= acc_nxt;
            endcase
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### design/keyframe_sampler_interp.sv
// keyframe_sampler_interp: top level; configuration registers, front queue
// and execution sequencer. Uses kfsi_pkg, kfsi_front, kfsi_back.
//
// Usage: pulse start with a command word while busy is low. Operation 0
// loads a key time, 1 loads a key vector (in-tangent, value or out-tangent),
// 2 samples the channel. Loads give no result; a sample gives one result word
// on out_* marked by out_valid for one cycle, or none when the key count is
// zero. The receiver cannot stall, so results are simply presented. Words go
// into a two-entry queue; busy rises when it is full.
// Timing: a load is executed in the cycle it leaves the queue. A sample
// reads one table entry per cycle for the max scan and again for the bracket
// search, uses the divider when the time wraps and again when the fraction
// needs it, then works through each used component (cubic first forms the
// basis terms once). The sequencer takes no new word from the queue while a
// sample runs.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset clears the queue, the sequencer and the registers to their defaults;
// table contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_sampler_interp #(
  parameter int MAX_KEYS       = 256,
  parameter int NUM_COMPONENTS = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire [1:0]         in_operation,
  input  wire [7:0]         in_key_index,
  input  wire [1:0]         in_vector_slot,
  input  wire [31:0]        in_key_time,
  input  wire signed [31:0] in_comp_x,
  input  wire signed [31:0] in_comp_y,
  input  wire signed [31:0] in_comp_z,
  input  wire signed [31:0] in_comp_w,
  input  wire [16:0]        in_play_fraction,
  output logic              out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic [7:0]        out_start_key,
  output logic [7:0]        out_end_key,
  input  wire               cfg_we,
  input  wire [1:0]         cfg_index,
  input  wire [31:0]        cfg_wdata
);
  import kfsi_pkg::*;

  cfg_t             cfg_r;
  logic             q_valid, q_take;
  item_t            q_item;
  logic [3:0][31:0] comps, res;

  assign comps = {in_comp_w, in_comp_z, in_comp_y, in_comp_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_LINEAR;
      cfg_r.key_count  <= 9'd1;
      cfg_r.duration   <= 32'd65536;
      cfg_r.comp_count <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     cfg_r.mode       <= cfg_wdata[1:0];
        CFG_KEYS:     cfg_r.key_count  <= cfg_wdata[8:0];
        CFG_DURATION: cfg_r.duration   <= cfg_wdata;
        CFG_COMPS:    cfg_r.comp_count <= cfg_wdata[2:0];
        default:      ;
      endcase
    end
  end

  kfsi_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_key_index     (in_key_index),
    .in_vector_slot   (in_vector_slot),
    .in_key_time      (in_key_time),
    .in_comps         (comps),
    .in_play_fraction (in_play_fraction),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_take           (q_take)
  );

  kfsi_back #(.MAX_KEYS(MAX_KEYS), .NUM_COMPONENTS(NUM_COMPONENTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_take        (q_take),
    .out_valid     (out_valid),
    .out_comps     (res),
    .out_start_key (out_start_key),
    .out_end_key   (out_end_key)
  );

  assign out_x = res[0];
  assign out_y = res[1];
  assign out_z = res[2];
  assign out_w = res[3];

  // out_valid drops again after each result word is shown
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for two cycles");

  // bracketing keys are equal or adjacent
  a_adjacent_keys: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_start_key == out_end_key) ||
                  ((out_start_key + 8'd1) == out_end_key))
    else $error("bracketing keys not adjacent");

  // no result strobe right after a reset cycle
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for keyframe_sampler_interp (step, linear and cubic sampling).
// Depends on design/kfsi_pkg.sv and design/keyframe_sampler_interp.sv.
`timescale 1ns / 1ps
module tb;
  import kfsi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1000;
  localparam int RANDOM_WORDS   = 600;

  typedef struct packed {
    logic [3:0][31:0] comp;
    logic [7:0]       start_key;
    logic [7:0]       end_key;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [7:0] in_key_index = '0;
  logic [1:0] in_vector_slot = '0;
  logic [31:0] in_key_time = '0;
  logic signed [31:0] in_comp_x = '0, in_comp_y = '0, in_comp_z = '0, in_comp_w = '0;
  logic [16:0] in_play_fraction = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic [7:0] out_start_key, out_end_key;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor state
  logic [31:0]        key_times [256];
  logic signed [31:0] key_vecs [256][3][4];
  logic [1:0]  cur_mode = MODE_LINEAR;
  logic [8:0]  cur_keys = 9'd1;
  logic [31:0] cur_duration = 32'd65536;
  logic [2:0]  cur_comps = 3'd3;

  sample_t expected_samples[$];
  string comp_names [4] = '{"out_x", "out_y", "out_z", "out_w"};
  int errors = 0;
  int idle_pct = 36;
  int random_words = 0;
  int samples_checked = 0;
  int words_sent = 0;
  int quiet_cycles = 0;

  keyframe_sampler_interp uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key_index(in_key_index),
    .in_vector_slot(in_vector_slot), .in_key_time(in_key_time),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .in_comp_w(in_comp_w), .in_play_fraction(in_play_fraction),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
    .out_start_key(out_start_key), .out_end_key(out_end_key),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit predict_sample(input logic [16:0] pf, output sample_t r);
    int unsigned n, s, e, used;
    longint unsigned tq, mx, last;
    longint num, den, d, p0, p1, m0, m1, t2, t3, h00, h10, h01, h11, acc;
    r = '0;
    if (cur_keys == 0) return 1'b0;
    n = (cur_keys > 256) ? 256 : cur_keys;
    tq = (longint'(pf) * longint'(cur_duration)) >> 16;
    mx = 0;
    for (int i = 0; i < n; i++)
      if (key_times[i] > mx) mx = key_times[i];
    last = key_times[n-1];
    if (tq > mx) begin
      if (last == 0) tq = mx;
      else tq = tq - ((tq - mx + last - 1) / last) * last;
    end
    s = 0;
    e = 0;
    if (tq > key_times[0]) begin
      for (e = 1; e < n; e++)
        if (tq <= key_times[e]) break;
      if (e >= n) e = n - 1;
      s = e - 1;
    end
    num = longint'(tq) - longint'(key_times[s]);
    den = longint'(key_times[e]) - longint'(key_times[s]);
    d = 0;
    if (den != 0 && num != 0 && ((num > 0) == (den > 0))) begin
      num = (num < 0) ? -num : num;
      den = (den < 0) ? -den : den;
      d = (num >= den) ? 65536 : (num <<< 16) / den;
      den = longint'(key_times[e]) - longint'(key_times[s]);
    end
    used = (cur_comps > 4) ? 4 : cur_comps;
    for (int c = 0; c < 4; c++) begin
      acc = 0;
      if (c < used) begin
        p0 = key_vecs[s][SLOT_VALUE][c];
        p1 = key_vecs[e][SLOT_VALUE][c];
        if (cur_mode == MODE_LINEAR) begin
          acc = p0 + (((p1 - p0) * d) >>> 16);
        end else if (cur_mode == MODE_CUBIC && s != e) begin
          m0 = (den * longint'(key_vecs[s][SLOT_OUT][c])) >>> 16;
          m1 = (den * longint'(key_vecs[e][SLOT_IN][c])) >>> 16;
          t2 = (d * d) >>> 16;
          t3 = (t2 * d) >>> 16;
          h00 = 2 * t3 - 3 * t2 + 65536;
          h10 = t3 - 2 * t2 + d;
          h01 = 3 * t2 - 2 * t3;
          h11 = t3 - t2;
          acc = (h00 * p0 + h10 * m0 + h01 * p1 + h11 * m1) >>> 16;
        end else begin
          acc = p0;
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      end
      r.comp[c] = acc[31:0];
    end
    r.start_key = s[7:0];
    r.end_key = e[7:0];
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_comp();
    logic [31:0] pick [4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    case ($urandom_range(3))
      0: return $urandom;
      1: return pick[$urandom_range(3)];
      default: return $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  function automatic logic [3:0][31:0] rand_vec();
    logic [3:0][31:0] v;
    for (int c = 0; c < 4; c++) v[c] = rand_comp();
    return v;
  endfunction

  // one word through the start/busy handshake, then the predictor
  task automatic send_word(input logic [1:0] op, input logic [7:0] idx, input logic [1:0] slot,
                           input logic [31:0] kt, input logic [3:0][31:0] v,
                           input logic [16:0] pf, input bit counted);
    bit ok;
    sample_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_key_index <= idx;
    in_vector_slot <= slot;
    in_key_time <= kt;
    in_comp_x <= v[0];
    in_comp_y <= v[1];
    in_comp_z <= v[2];
    in_comp_w <= v[3];
    in_play_fraction <= pf;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    words_sent++;
    if (counted) random_words++;
    case (op)
      OP_LOAD_TIME: key_times[idx] = kt;
      OP_LOAD_VEC: begin
        if (slot <= SLOT_OUT)
          for (int c = 0; c < 4; c++) key_vecs[idx][slot][c] = v[c];
      end
      OP_SAMPLE: if (predict_sample(pf, r)) expected_samples.push_back(r);
      default: ;
    endcase
  endtask

  task automatic load_vecs(input logic [7:0] k, input bit counted);
    send_word(OP_LOAD_VEC, k, SLOT_IN, $urandom, rand_vec(), 17'($urandom_range(65536)),
              counted);
    send_word(OP_LOAD_VEC, k, SLOT_VALUE, $urandom, rand_vec(), 17'($urandom_range(65536)),
              counted);
    send_word(OP_LOAD_VEC, k, SLOT_OUT, $urandom, rand_vec(), 17'($urandom_range(65536)),
              counted);
  endtask

  task automatic load_key(input int k, input logic [31:0] kt, input bit counted);
    send_word(OP_LOAD_TIME, k[7:0], SLOT_IN, kt, rand_vec(), 17'($urandom_range(65536)),
              counted);
    load_vecs(k[7:0], counted);
  endtask

  task automatic sample_at(input logic [16:0] pf, input bit counted);
    send_word(OP_SAMPLE, 8'($urandom), 2'($urandom), $urandom, rand_vec(), pf, counted);
  endtask

  // load the vectors of the two keys around the sample point, then sample
  task automatic sample_bracketed(input logic [16:0] pf);
    sample_t r;
    if (predict_sample(pf, r)) begin
      load_vecs(r.start_key, 1'b0);
      load_vecs(r.end_key, 1'b0);
    end
    sample_at(pf, 1'b0);
  endtask

  // drain outstanding samples, then give a trailing load time to finish
  task automatic settle();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [1:0] mode, input logic [8:0] keys,
                              input logic [31:0] dur, input logic [2:0] comps);
    logic [31:0] vals [4];
    vals = '{32'(mode), 32'(keys), dur, 32'(comps)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_mode = mode;
    cur_keys = keys;
    cur_duration = dur;
    cur_comps = comps;
  endtask

  task automatic test_defaults();
    load_key(0, 32'd0, 1'b0);
    sample_at(17'd0, 1'b0);
    sample_at(17'd65536, 1'b0);
  endtask

  task automatic test_modes();
    settle();
    program_regs(MODE_STEP, 9'd3, 32'd3 << 16, 3'd4);
    load_key(0, 32'd0, 1'b0);
    load_key(1, 32'd1 << 16, 1'b0);
    load_key(2, 32'd2 << 16, 1'b0);
    send_word(OP_LOAD_VEC, 8'd1, SLOT_VALUE, 32'd0,
              {32'hffffffff, 32'h0, 32'h80000000, 32'h7fffffff}, 17'd0, 1'b0);
    for (int m = 0; m < 4; m++) begin
      settle();
      program_regs(m[1:0], 9'd3, 32'd3 << 16, 3'd4);
      sample_at(17'd0, 1'b0);
      sample_at(17'd21845, 1'b0);
      sample_at(17'd32768, 1'b0);
      sample_at(17'd65536, 1'b0);
    end
  endtask

  // zero last time clamps; zero keys; component counts 0 and above four; ignored loads; mode code 3
  task automatic test_special_cases();
    settle();
    program_regs(MODE_CUBIC, 9'd3, 32'hffffffff, 3'd7);
    load_key(0, 32'd0, 1'b0);
    load_key(1, 32'd2 << 16, 1'b0);
    load_key(2, 32'd0, 1'b0);
    sample_at(17'd65536, 1'b0);
    sample_at(17'd30000, 1'b0);
    send_word(2'd3, 8'd1, SLOT_VALUE, 32'hffffffff, rand_vec(), 17'd1, 1'b0);
    send_word(OP_LOAD_VEC, 8'd1, 2'd3, 32'd0, rand_vec(), 17'd0, 1'b0);
    sample_at(17'd1, 1'b0);
    settle();
    program_regs(MODE_LINEAR, 9'd0, 32'hffffffff, 3'd0);
    sample_at(17'd40000, 1'b0);
    settle();
    program_regs(2'd3, 9'd2, 32'hffffffff, 3'd0);
    sample_at(17'd40000, 1'b0);
  endtask

  // key count above the table size, all 256 key times, widest duration
  task automatic test_full_table();
    settle();
    program_regs(MODE_CUBIC, 9'd511, 32'hffffffff, 3'd4);
    for (int k = 0; k < 256; k++)
      send_word(OP_LOAD_TIME, k[7:0], SLOT_IN, 32'(k) * 32'd160000 + 32'd7, rand_vec(),
                17'($urandom_range(65536)), 1'b0);
    sample_bracketed(17'd0);
    sample_bracketed(17'd65536);
    sample_bracketed(17'($urandom_range(65536)));
    settle();
    program_regs(MODE_LINEAR, 9'd256, 32'hffffffff, 3'd4);
    sample_bracketed(17'($urandom_range(65536)));
    sample_bracketed(17'd65535);
  endtask

  task automatic test_random_phase();
    int n, kc, step_max, samples;
    logic [31:0] kt, dur;
    bit sorted;
    settle();
    case ($urandom_range(19))
      0: kc = 0;
      1, 2: kc = $urandom_range(13, 40);
      default: kc = $urandom_range(1, 12);
    endcase
    case ($urandom_range(5))
      0: dur = 32'd0;
      1: dur = 32'hffffffff;
      2: dur = $urandom;
      default: dur = $urandom_range(0, 64 << 16);
    endcase
    program_regs(2'($urandom_range(3)), kc[8:0], dur,
                 3'(($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1, 4)));
    n = (kc == 0) ? 1 : kc;
    sorted = ($urandom_range(4) != 0);
    step_max = ($urandom_range(1) == 0) ? (8 << 16) : 32'h7fffffff / n;
    kt = ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(0, 4 << 16);
    for (int k = 0; k < n; k++) begin
      if (!sorted) kt = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      else if (k > 0) kt = kt + (($urandom_range(5) == 0) ? 0 : $urandom_range(0, step_max));
      load_key(k, kt, 1'b1);
      if ($urandom_range(15) == 0)
        send_word(($urandom_range(1) == 0) ? 2'd3 : OP_LOAD_VEC, k[7:0], 2'd3, $urandom,
                  rand_vec(), 17'($urandom_range(65536)), 1'b0);
    end
    samples = $urandom_range(5, 20);
    for (int i = 0; i < samples; i++) begin
      case ($urandom_range(9))
        0: sample_at(17'd0, 1'b1);
        1: sample_at(17'd65536, 1'b1);
        default: sample_at(17'($urandom_range(65536)), 1'b1);
      endcase
    end
  endtask

  // result check and watchdog
  always @(negedge clk) begin
    sample_t want;
    logic [3:0][31:0] got;
    if (out_valid || (start && !busy)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      got = {out_w, out_z, out_y, out_x};
      if (expected_samples.size() == 0) begin
        $error("result word with no sample pending");
        errors++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        for (int c = 0; c < 4; c++)
          if (got[c] !== want.comp[c]) begin
            $error("%s: expected %h, got %h", comp_names[c], want.comp[c], got[c]);
            errors++;
          end
        if (out_start_key !== want.start_key) begin
          $error("out_start_key: expected %0d, got %0d", want.start_key, out_start_key);
          errors++;
        end
        if (out_end_key !== want.end_key) begin
          $error("out_end_key: expected %0d, got %0d", want.end_key, out_end_key);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 36;
    test_defaults();
    test_modes();
    test_special_cases();
    test_full_table();
    while (random_words < RANDOM_WORDS) begin
      if (random_words >= 2 * RANDOM_WORDS / 3) idle_pct = 0;
      else if (random_words >= RANDOM_WORDS / 3) idle_pct = 79;
      test_random_phase();
    end
    settle();
    $display("covered: %0d words sent, %0d samples checked across step, linear, cubic",
             words_sent, samples_checked);
    $display("and fallback modes, wrap, clamp, zero keys and a full 256-key table");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
